FILE: rtl/sws_pkg.sv
// sws_pkg: shared widths, constants and the command/status types of the
// sliding window statistics block. Depends on nothing.
`default_nettype none

package sws_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DEPTH    = 1024;
	localparam int PTR_W    = 10;
	localparam int CNT_W    = 11;
	localparam int SUM_W    = 27;
	localparam int MAG_W    = 26;
	localparam int SQ_W     = 41;
	localparam int PROD_W   = 52;
	localparam int DEN_W    = 20;
	localparam int MEAN_W   = 16;
	localparam int VAR_W    = 31;
	localparam int OUT_W    = 96;
	localparam int QCNT_W   = 6;

	localparam logic [CNT_W-1:0]    WLEN_RESET = CNT_W'(1000);
	localparam logic [CNT_W-1:0]    DEPTH_CNT  = CNT_W'(DEPTH);
	localparam logic [SAMPLE_W-1:0] SMAX       = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SMIN       = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [VAR_W-1:0]    VAR_MAX    = {VAR_W{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic take;
		logic drop;
		logic ins;
		logic scan_start;
		logic mul_nsq;
		logic mul_sum;
		logic save_p1;
		logic div_var;
		logic save_var;
		logic div_mean;
		logic save_mean;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_drop;
		logic scan_busy;
		logic mul_busy;
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_statistics.sv
// sliding_window_statistics: top level joining controller and datapath.
// Depends on sws_pkg, sws_ctrl, sws_dp, sws_div.
//
// Usage: requests enter on the s_ channel; s_tuser selects insert (0) or
// clear (1), s_tdata carries the signed sample. Each request gives one
// result on the m_ channel: count, mean, variance, min and max of the window.
// One request is in work at a time; s_tready is high only while idle.
// Each request runs through two 52-step divisions, a shift-add multiply of up
// to 11 and one of up to 26 steps, and the control states; the next request
// is taken in the cycle after the result is loaded.
// When the dropped sample was the window minimum or maximum, the extreme is
// rescanned from the ring memory one entry per cycle, over the whole window.
// The result waits in an output register; the next request is taken while it
// waits, and its result is held back until the receiver takes the first.
// Reset: window length 1000, window empty, no result pending; the ring needs
// no clearing. cfg_we writes window_length and clears the window; write it
// only while no request is in work.
`default_nettype none

module sliding_window_statistics (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [10:0] cfg_wdata,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // sample
	input  wire  [0:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata    // count, mean, variance, min_value, max_value
);

	sws_pkg::cmd_t  cmd;
	sws_pkg::stat_t stat;

	sws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.in_clear (s_tuser[0]),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sws_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_clear  (s_tuser[0]),
		.in_sample (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire

FILE: rtl/sws_div.sv
// sws_div: restoring divider, one quotient bit per cycle.
// Depends on sws_pkg for widths.
`default_nettype none

module sws_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire  [sws_pkg::PROD_W-1:0]    num,
	input  wire  [sws_pkg::DEN_W-1:0]     den,
	output logic [sws_pkg::PROD_W-1:0]    quo,
	output logic                          busy
);

	logic [sws_pkg::QCNT_W-1:0]  cnt_q;
	logic [sws_pkg::PROD_W-1:0]  quo_q;
	logic [sws_pkg::DEN_W-1:0]   rem_q;
	logic [sws_pkg::DEN_W-1:0]   den_q;
	logic [sws_pkg::DEN_W:0]     trial;
	logic                        fits;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[sws_pkg::PROD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= sws_pkg::QCNT_W'(sws_pkg::PROD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[sws_pkg::PROD_W-2:0], fits};
			rem_q <= fits ? sws_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[sws_pkg::DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign busy = cnt_q != '0;

endmodule

`default_nettype wire

FILE: rtl/sws_ctrl.sv
// sws_ctrl: sequencer of one request through drop, insert, rescan,
// multiply and divide steps. Depends on sws_pkg for cmd_t and stat_t.
`default_nettype none

module sws_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  in_clear,
	output logic                 s_tready,
	input  sws_pkg::stat_t       stat,
	output sws_pkg::cmd_t        cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RDOLD = 4'd1;
	localparam logic [3:0] ST_DROP  = 4'd2;
	localparam logic [3:0] ST_INS   = 4'd3;
	localparam logic [3:0] ST_SGO   = 4'd4;
	localparam logic [3:0] ST_SCAN  = 4'd5;
	localparam logic [3:0] ST_M1    = 4'd6;
	localparam logic [3:0] ST_M1W   = 4'd7;
	localparam logic [3:0] ST_M2    = 4'd8;
	localparam logic [3:0] ST_M2W   = 4'd9;
	localparam logic [3:0] ST_DV    = 4'd10;
	localparam logic [3:0] ST_DVW   = 4'd11;
	localparam logic [3:0] ST_DM    = 4'd12;
	localparam logic [3:0] ST_DMW   = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign s_tready = state_q == ST_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (in_clear) state_d = ST_M1;
					else if (stat.need_drop) state_d = ST_RDOLD;
					else state_d = ST_INS;
				end
			end
			ST_RDOLD: state_d = ST_DROP;
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = ST_INS;
			end
			ST_INS: begin
				cmd.ins = 1'b1;
				state_d = ST_SGO;
			end
			ST_SGO: begin
				cmd.scan_start = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: if (!stat.scan_busy) state_d = ST_M1;
			ST_M1: begin
				cmd.mul_nsq = 1'b1;
				state_d     = ST_M1W;
			end
			ST_M1W: begin
				if (!stat.mul_busy) begin
					cmd.save_p1 = 1'b1;
					state_d     = ST_M2;
				end
			end
			ST_M2: begin
				cmd.mul_sum = 1'b1;
				state_d     = ST_M2W;
			end
			ST_M2W: if (!stat.mul_busy) state_d = ST_DV;
			ST_DV: begin
				cmd.div_var = 1'b1;
				state_d     = ST_DVW;
			end
			ST_DVW: begin
				if (!stat.div_busy) begin
					cmd.save_var = 1'b1;
					state_d      = ST_DM;
				end
			end
			ST_DM: begin
				cmd.div_mean = 1'b1;
				state_d      = ST_DMW;
			end
			ST_DMW: begin
				if (!stat.div_busy) begin
					cmd.save_mean = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sws_dp.sv
// sws_dp: sample ring, running sums, extremes, rescan, shift-add multiplier,
// divider and output register. Depends on sws_pkg and sws_div.
`default_nettype none

module sws_dp (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [sws_pkg::CNT_W-1:0]      cfg_wdata,
	input  wire                            in_clear,
	input  wire  [sws_pkg::SAMPLE_W-1:0]   in_sample,
	input  sws_pkg::cmd_t                  cmd,
	output sws_pkg::stat_t                 stat,
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [sws_pkg::OUT_W-1:0]      m_tdata
);

	localparam int SW = sws_pkg::SAMPLE_W;

	logic [SW-1:0]                  ring [sws_pkg::DEPTH];
	logic signed [SW-1:0]           rd_q;
	logic signed [SW-1:0]           x_q;
	logic signed [SW-1:0]           old_q;
	logic [sws_pkg::CNT_W-1:0]      wlen_q;
	logic [sws_pkg::PTR_W-1:0]      wptr_q;
	logic [sws_pkg::CNT_W-1:0]      fill_q;
	logic signed [sws_pkg::SUM_W-1:0] sum_q;
	logic [sws_pkg::SQ_W-1:0]       sq_q;
	logic signed [SW-1:0]           min_q;
	logic signed [SW-1:0]           max_q;
	logic                           dropped_q;
	logic                           do_min_q;
	logic                           do_max_q;
	logic [sws_pkg::PTR_W-1:0]      scan_addr_q;
	logic [sws_pkg::CNT_W-1:0]      scan_left_q;
	logic                           pend_q;
	logic [sws_pkg::PROD_W-1:0]     mul_a_q;
	logic [sws_pkg::MAG_W-1:0]      mul_b_q;
	logic [sws_pkg::PROD_W-1:0]     acc_q;
	logic [sws_pkg::PROD_W-1:0]     p1_q;
	logic [sws_pkg::MEAN_W-1:0]     mean_q;
	logic [sws_pkg::VAR_W-1:0]      var_q;
	logic                           m_tvalid_q;
	logic [sws_pkg::OUT_W-1:0]      m_tdata_q;

	logic [sws_pkg::CNT_W-1:0]      eff_len;
	logic [sws_pkg::PTR_W-1:0]      oldest;
	logic [sws_pkg::PTR_W-1:0]      rd_addr;
	logic signed [2*SW-1:0]         xsq;
	logic signed [2*SW-1:0]         oldsq;
	logic signed [SW-1:0]           new_min;
	logic signed [SW-1:0]           new_max;
	logic [sws_pkg::SUM_W-1:0]      sum_abs;
	logic [sws_pkg::MAG_W-1:0]      mag;
	logic [2*sws_pkg::CNT_W-1:0]    nn;
	logic                           div_start;
	logic [sws_pkg::PROD_W-1:0]     div_num;
	logic [sws_pkg::DEN_W-1:0]      div_den;
	logic [sws_pkg::PROD_W-1:0]     quo;
	logic                           div_busy;
	logic [sws_pkg::MEAN_W:0]       mean_mag;

	// effective window length and oldest ring entry
	always_comb begin
		if (wlen_q == '0) eff_len = sws_pkg::CNT_W'(1);
		else if (wlen_q > sws_pkg::DEPTH_CNT) eff_len = sws_pkg::DEPTH_CNT;
		else eff_len = wlen_q;
	end
	assign oldest  = wptr_q - fill_q[sws_pkg::PTR_W-1:0];
	assign rd_addr = (scan_left_q != '0) ? scan_addr_q : oldest;

	assign xsq     = x_q * x_q;
	assign oldsq   = rd_q * rd_q;
	assign new_min = (x_q < min_q) ? x_q : min_q;
	assign new_max = (x_q > max_q) ? x_q : max_q;
	assign sum_abs = sum_q[sws_pkg::SUM_W-1] ? sws_pkg::SUM_W'(-sum_q) : sum_q;
	assign mag     = sum_abs[sws_pkg::MAG_W-1:0];
	assign nn      = fill_q * (fill_q - 1'b1);

	// sample ring, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.ins) ring[wptr_q] <= x_q;
		rd_q <= ring[rd_addr];
	end

	// request payload and dropped sample
	always_ff @(posedge clk) begin
		if (cmd.take) x_q <= in_sample;
		if (cmd.drop) old_q <= rd_q;
	end

	// window state: pointer, count, sums, extremes, rescan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q      <= sws_pkg::WLEN_RESET;
			wptr_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sq_q        <= '0;
			min_q       <= sws_pkg::SMAX;
			max_q       <= sws_pkg::SMIN;
			dropped_q   <= 1'b0;
			do_min_q    <= 1'b0;
			do_max_q    <= 1'b0;
			scan_addr_q <= '0;
			scan_left_q <= '0;
			pend_q      <= 1'b0;
		end else if (cfg_we || (cmd.take && in_clear)) begin
			if (cfg_we) wlen_q <= cfg_wdata;
			wptr_q    <= '0;
			fill_q    <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			min_q     <= sws_pkg::SMAX;
			max_q     <= sws_pkg::SMIN;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.take) dropped_q <= 1'b0;
			if (cmd.drop) begin
				dropped_q <= 1'b1;
				fill_q    <= fill_q - 1'b1;
				sum_q     <= sum_q - {{(sws_pkg::SUM_W-SW){rd_q[SW-1]}}, rd_q};
				sq_q      <= sq_q - sws_pkg::SQ_W'(unsigned'(oldsq));
			end
			if (cmd.ins) begin
				wptr_q   <= wptr_q + 1'b1;
				fill_q   <= fill_q + 1'b1;
				sum_q    <= sum_q + {{(sws_pkg::SUM_W-SW){x_q[SW-1]}}, x_q};
				sq_q     <= sq_q + sws_pkg::SQ_W'(unsigned'(xsq));
				min_q    <= new_min;
				max_q    <= new_max;
				do_max_q <= dropped_q && (old_q >= new_max);
				do_min_q <= dropped_q && (old_q <= new_min);
			end
			if (cmd.scan_start) begin
				if (do_max_q) max_q <= sws_pkg::SMIN;
				if (do_min_q) min_q <= sws_pkg::SMAX;
				scan_addr_q <= oldest;
				scan_left_q <= (do_max_q || do_min_q) ? fill_q : '0;
			end else begin
				pend_q <= scan_left_q != '0;
				if (scan_left_q != '0) begin
					scan_addr_q <= scan_addr_q + 1'b1;
					scan_left_q <= scan_left_q - 1'b1;
				end
				if (pend_q) begin
					if (do_max_q && rd_q > max_q) max_q <= rd_q;
					if (do_min_q && rd_q < min_q) min_q <= rd_q;
				end
			end
		end
	end

	// shift-add multiplier, one bit of the multiplier per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_b_q <= '0;
		end else if (cmd.mul_nsq) begin
			mul_b_q <= sws_pkg::MAG_W'(fill_q);
		end else if (cmd.mul_sum) begin
			mul_b_q <= mag;
		end else begin
			mul_b_q <= mul_b_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_nsq) begin
			mul_a_q <= sws_pkg::PROD_W'(sq_q);
			acc_q   <= '0;
		end else if (cmd.mul_sum) begin
			mul_a_q <= sws_pkg::PROD_W'(mag);
			acc_q   <= '0;
		end else if (mul_b_q != '0) begin
			mul_a_q <= mul_a_q << 1;
			if (mul_b_q[0]) acc_q <= acc_q + mul_a_q;
		end
		if (cmd.save_p1) p1_q <= acc_q;
	end

	// divider shared by variance and mean
	assign div_start = cmd.div_var || cmd.div_mean;
	assign div_num   = cmd.div_var ? (p1_q - acc_q) : sws_pkg::PROD_W'(mag);
	assign div_den   = cmd.div_var ? nn[sws_pkg::DEN_W-1:0] : sws_pkg::DEN_W'(fill_q);

	sws_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (quo),
		.busy   (div_busy)
	);

	// signed, gated results
	assign mean_mag = quo[sws_pkg::MEAN_W:0];
	always_ff @(posedge clk) begin
		if (cmd.save_var) begin
			if (fill_q < sws_pkg::CNT_W'(2)) var_q <= '0;
			else if (quo > sws_pkg::PROD_W'(sws_pkg::VAR_MAX)) var_q <= sws_pkg::VAR_MAX;
			else var_q <= quo[sws_pkg::VAR_W-1:0];
		end
		if (cmd.save_mean) begin
			if (fill_q == '0) mean_q <= '0;
			else if (sum_q[sws_pkg::SUM_W-1]) mean_q <= sws_pkg::MEAN_W'(-mean_mag);
			else mean_q <= mean_mag[sws_pkg::MEAN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= {6'b0, max_q, min_q, var_q, mean_q, fill_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// status to the controller
	assign stat.need_drop = fill_q >= eff_len;
	assign stat.scan_busy = (scan_left_q != '0) || pend_q;
	assign stat.mul_busy  = mul_b_q != '0;
	assign stat.div_busy  = div_busy;
	assign stat.out_free  = !m_tvalid_q || m_tready;

endmodule

`default_nettype wire

FILE: rtl/sws_checker.sv
// sws_checker: port-level assertions for sliding_window_statistics and the
// bind that attaches them. Depends on the top level's ports only.
`default_nettype none

module sws_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [95:0] m_tdata
);

	// a pending result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// one request in work at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// count never above the ring depth
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[10:0] <= 11'd1024)
		else $error("count out of range");

	// empty window shows neutral values
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:0] == 11'd0 |->
			m_tdata[26:11] == 16'd0 && m_tdata[73:58] == 16'h7fff
			&& m_tdata[89:74] == 16'h8000)
		else $error("empty window result wrong");

	// variance zero below two samples
	a_var: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:0] < 11'd2 |-> m_tdata[57:27] == 31'd0)
		else $error("variance nonzero for short window");

endmodule

bind sliding_window_statistics sws_checker u_sws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/sws_checker.sv
// sws_scoreboard: watches the request and result channels of the sliding window
// statistics block, predicts each result and compares field by field.
// Depends on sws_pkg.
`default_nettype none

module sws_scoreboard (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [10:0] cfg_wdata,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [15:0] s_tdata,
	input  wire  [0:0]  s_tuser,
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [95:0] m_tdata,
	output int          errors,
	output int          pending
);

	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		logic [sws_pkg::SAMPLE_W-1:0] max_value;
		logic [sws_pkg::SAMPLE_W-1:0] min_value;
		logic [sws_pkg::VAR_W-1:0]    variance;
		logic [sws_pkg::MEAN_W-1:0]   mean;
		logic [sws_pkg::CNT_W-1:0]    count;
	} stats_t;

	// expected results in request order
	stats_t      exp_mem [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;

	// predictor state
	logic signed [15:0] win_ring [sws_pkg::DEPTH];
	int          wr_ptr;
	int          fill;
	longint      sum_x;
	longint      sum_sq;
	longint      win_min;
	longint      win_max;
	int          win_len;

	function automatic void exp_put(stats_t s);
		exp_mem[exp_wr % EXP_DEPTH] = s;
		exp_wr++;
	endfunction

	function automatic stats_t exp_get();
		stats_t s;
		s = exp_mem[exp_rd % EXP_DEPTH];
		exp_rd++;
		return s;
	endfunction

	function automatic void clear_win();
		wr_ptr  = 0;
		fill    = 0;
		sum_x   = 0;
		sum_sq  = 0;
		win_min = 32767;
		win_max = -32768;
	endfunction

	function automatic int eff_len();
		if (win_len == 0) return 1;
		if (win_len > sws_pkg::DEPTH) return sws_pkg::DEPTH;
		return win_len;
	endfunction

	function automatic void add_sample(longint x);
		longint old;
		int     idx;
		bit     dropped;
		dropped = 0;
		old = 0;
		if (fill >= eff_len()) begin
			old = win_ring[(wr_ptr + sws_pkg::DEPTH - fill) % sws_pkg::DEPTH];
			sum_x  -= old;
			sum_sq -= old * old;
			fill--;
			dropped = 1;
		end
		win_ring[wr_ptr] = 16'(x);
		wr_ptr = (wr_ptr + 1) % sws_pkg::DEPTH;
		fill++;
		sum_x  += x;
		sum_sq += x * x;
		if (x < win_min) win_min = x;
		if (x > win_max) win_max = x;
		if (dropped) begin
			bit do_max, do_min;
			do_max = old >= win_max;
			do_min = old <= win_min;
			if (do_max) win_max = -32768;
			if (do_min) win_min = 32767;
			idx = (wr_ptr + sws_pkg::DEPTH - fill) % sws_pkg::DEPTH;
			for (int k = 0; k < fill; k++) begin
				if (do_max && win_ring[idx] > win_max) win_max = win_ring[idx];
				if (do_min && win_ring[idx] < win_min) win_min = win_ring[idx];
				idx = (idx + 1) % sws_pkg::DEPTH;
			end
		end
	endfunction

	function automatic stats_t window_stats();
		stats_t r;
		longint avg, mag, v;
		avg = 0;
		v = 0;
		if (fill > 0) avg = sum_x / fill;
		if (fill > 1) begin
			mag = sum_x < 0 ? -sum_x : sum_x;
			v = (fill * sum_sq - mag * mag) / (longint'(fill) * (fill - 1));
			if (v > 64'sd2147483647) v = 64'sd2147483647;
		end
		r.count     = fill[sws_pkg::CNT_W-1:0];
		r.mean      = avg[sws_pkg::MEAN_W-1:0];
		r.variance  = v[sws_pkg::VAR_W-1:0];
		r.min_value = win_min[15:0];
		r.max_value = win_max[15:0];
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, got, want);
	endtask

	assign pending = exp_wr - exp_rd;

	// predict on each request, compare on each result
	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		if (!arst_n) begin
			win_len = 1000;
			clear_win();
			exp_wr = 0;
			exp_rd = 0;
			errors = 0;
		end else begin
			if (cfg_we) begin
				win_len = 32'(cfg_wdata);
				clear_win();
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0]) clear_win();
				else add_sample(longint'($signed(s_tdata)));
				exp_put(window_stats());
			end
			if (m_tvalid && m_tready) begin
				got = stats_t'(m_tdata[sws_pkg::CNT_W+sws_pkg::MEAN_W+sws_pkg::VAR_W
					+2*sws_pkg::SAMPLE_W-1:0]);
				if (exp_wr == exp_rd) begin
					report("unexpected result", '0, '0);
				end else begin
					want = exp_get();
					if (got.count != want.count)
						report("count", 32'(got.count), 32'(want.count));
					if (got.mean != want.mean)
						report("mean", 32'(got.mean), 32'(want.mean));
					if (got.variance != want.variance)
						report("variance", 32'(got.variance), 32'(want.variance));
					if (got.min_value != want.min_value)
						report("min_value", 32'(got.min_value), 32'(want.min_value));
					if (got.max_value != want.max_value)
						report("max_value", 32'(got.max_value), 32'(want.max_value));
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// tb_top: stimulus for the sliding window statistics block: directed edge
// cases, then random samples over several window lengths with random stalls.
// Depends on sws_pkg, sliding_window_statistics and sws_scoreboard.
`default_nettype none

module tb_top;

	localparam longint CYCLE_LIMIT = 10000000;
	localparam int     REQ_INSERT  = 0;
	localparam int     REQ_CLEAR   = 1;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	int          errors;
	int          pending;
	longint      cycles;

	sliding_window_statistics dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	sws_scoreboard chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// receiver stalls for a random gap before taking each result
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 4);
			repeat (gap) @(posedge clk);
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			m_tready <= 0;
		end
	end

	task automatic send(int kind, logic [15:0] value);
		int gap;
		gap = $urandom_range(0, 4);
		repeat (gap) @(posedge clk);
		s_tvalid <= 1;
		s_tuser  <= kind[0:0];
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 0;
	endtask

	task automatic write_len(logic [10:0] len);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 15) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [10:0] lens [8];
		int          per;
		lens = '{11'd1, 11'd2, 11'd0, 11'd3, 11'd2047, 11'd1024, 11'd17, 11'd6};
		arst_n    = 0;
		cfg_we    = 0;
		cfg_wdata = 0;
		s_tvalid  = 0;
		s_tdata   = 0;
		s_tuser   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty clear, extremes, default length
		send(REQ_CLEAR, 16'h1234);
		send(REQ_INSERT, 16'h7fff);
		send(REQ_INSERT, 16'h8000);
		send(REQ_INSERT, 16'h7fff);
		send(REQ_INSERT, 16'h8000);
		send(REQ_INSERT, 16'hffff);
		send(REQ_INSERT, 16'h0000);
		send(REQ_CLEAR, 16'hffff);
		send(REQ_INSERT, 16'hffff);
		// length two: dropped sample is an extreme
		write_len(11'd2);
		send(REQ_INSERT, 16'd5);
		send(REQ_INSERT, 16'd9);
		send(REQ_INSERT, 16'd7);
		send(REQ_INSERT, 16'd7);
		send(REQ_INSERT, 16'h8000);
		send(REQ_INSERT, 16'h7fff);
		send(REQ_INSERT, 16'h7fff);

		// random phases over several lengths, extremes among them
		foreach (lens[i]) begin
			write_len(lens[i]);
			per = (lens[i] > 100) ? 150 : 80;
			if (lens[i] == 11'd1024) begin
				// long run of full-scale samples in the widest window
				for (int k = 0; k < 300; k++)
					send(REQ_INSERT, ($urandom_range(0, 1) ? 16'h7fff : 16'h8000));
			end else begin
				for (int k = 0; k < per; k++)
					send(($urandom_range(0, 29) == 0) ? REQ_CLEAR : REQ_INSERT,
						rand_sample());
			end
		end

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sliding_window_statistics.f
rtl/sws_pkg.sv
rtl/sws_div.sv
rtl/sws_ctrl.sv
rtl/sws_dp.sv
rtl/sliding_window_statistics.sv
rtl/sws_checker.sv
tb/sws_checker.sv
tb/tb_top.sv
